// ===== rtl/irp_pkg.sv =====
// Package for the pool adjacent violators isotonic regression block.
// Holds the beat structs, block record type, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irp_pkg;

  localparam int MaxPoints = 1024;
  localparam int CountBits = 8;
  localparam int FracBits  = 16;
  localparam int IdxBits   = $clog2(MaxPoints);
  localparam int CntBits   = IdxBits + 1;
  localparam int SumBits   = CountBits + IdxBits;
  localparam int FitBits   = FracBits + 1;
  localparam int ProdBits  = 2 * SumBits;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [CountBits-1:0] successes;
    logic [CountBits-1:0] trials;
    logic [IdxBits-1:0]   point_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FitBits-1:0] fitted_value;
    logic [CntBits-1:0] points_held;
  } out_beat_t;

  typedef struct packed {
    logic [IdxBits-1:0] last;
    logic [SumBits-1:0] succ;
    logic [SumBits-1:0] trial;
  } blk_t;

endpackage
`default_nettype wire

// ===== rtl/isotonic_regression_pava.sv =====
// Top level of the pool adjacent violators isotonic regression block.
// Depends on irp_pkg; the block stack lives in one synchronous memory.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_data (in_beat_t)
//  out     | output    | out_valid/out_stall | out_data (out_beat_t)
//
// A push onto an empty stack goes straight to output; any other push passes through
// multiply and compare, plus a memory read, multiply and compare for each merge that
// pulls up a block from memory. A read does a binary search over block ends (a memory
// read and a compare per step), one more memory read when the block found is not the
// top one, then the divider. Clear, unknown commands and rejected beats go straight to output.
// Reset empties the stack at once; no clearing pass is needed.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module isotonic_regression_pava (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  irp_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output irp_pkg::out_beat_t out_data
);
  import irp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_CMP   = 10'b0000000100,
    S_MRD   = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_SCMP  = 10'b0000100000,
    S_FRD   = 10'b0001000000,
    S_DINIT = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  localparam int DivCntBits = $clog2(FracBits + 1);

  blk_t mem [MaxPoints];
  blk_t rdata;
  blk_t wdata;
  logic [IdxBits-1:0] raddr;
  logic [IdxBits-1:0] waddr;
  logic we;

  state_t state;
  blk_t top;
  blk_t cur;
  logic [CntBits-1:0] depth;
  logic [CntBits-1:0] point_count;
  logic [ProdBits-1:0] prod_a;
  logic [ProdBits-1:0] prod_b;
  logic [IdxBits-1:0] lo;
  logic [IdxBits-1:0] hi;
  logic [IdxBits-1:0] mid;
  logic [IdxBits-1:0] idx;
  logic [SumBits-1:0] div_num;
  logic [SumBits-1:0] div_den;
  logic [SumBits:0] rem;
  logic [SumBits:0] rem_sh;
  logic [FitBits-1:0] quot;
  logic [DivCntBits-1:0] div_cnt;
  logic [1:0] res_status;
  logic [FitBits-1:0] res_fit;
  logic merge;
  logic [IdxBits-1:0] mid_calc;
  logic [IdxBits-1:0] top_idx;
  logic in_data_was_read;

  assign in_stall = (state != S_IDLE);
  assign merge    = (prod_a > prod_b);
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign top_idx  = IdxBits'(depth - CntBits'(1));
  assign rem_sh   = {rem[SumBits-1:0], 1'b0};

  always_comb begin
    raddr = mid_calc;
    we    = 1'b0;
    waddr = top_idx;
    wdata = top;
    case (state)
      S_CMP: begin
        raddr = IdxBits'(depth - CntBits'(2));
        we    = !merge;
      end
      S_SRCH: begin
        raddr = (lo < hi) ? mid_calc : lo;
      end
      default: begin
        raddr = mid_calc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth       <= '0;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_status <= ST_OK;
            res_fit    <= '0;
            state      <= S_OUT;
            case (cmd_t'(in_data.command))
              CMD_PUSH: begin
                if (in_data.trials == '0 || in_data.successes > in_data.trials) begin
                  res_status <= ST_BAD;
                end else if (point_count >= CntBits'(MaxPoints)) begin
                  res_status <= ST_FULL;
                end else begin
                  point_count <= point_count + CntBits'(1);
                  cur.last    <= point_count[IdxBits-1:0];
                  cur.succ    <= SumBits'(in_data.successes);
                  cur.trial   <= SumBits'(in_data.trials);
                  if (depth == '0) begin
                    top.last  <= point_count[IdxBits-1:0];
                    top.succ  <= SumBits'(in_data.successes);
                    top.trial <= SumBits'(in_data.trials);
                    depth     <= CntBits'(1);
                  end else begin
                    state <= S_MUL;
                  end
                end
              end
              CMD_READ: begin
                idx <= in_data.point_index;
                if (CntBits'(in_data.point_index) >= point_count) begin
                  res_status <= ST_RANGE;
                end else begin
                  lo    <= '0;
                  hi    <= top_idx;
                  state <= S_SRCH;
                end
              end
              CMD_CLEAR: begin
                depth       <= '0;
                point_count <= '0;
              end
              default: begin
                res_status <= ST_OK;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_a <= top.succ * cur.trial;
          prod_b <= cur.succ * top.trial;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (merge) begin
            cur.succ  <= top.succ + cur.succ;
            cur.trial <= top.trial + cur.trial;
            if (depth == CntBits'(1)) begin
              top.last  <= cur.last;
              top.succ  <= top.succ + cur.succ;
              top.trial <= top.trial + cur.trial;
              state     <= S_OUT;
            end else begin
              depth <= depth - CntBits'(1);
              state <= S_MRD;
            end
          end else begin
            top   <= cur;
            depth <= depth + CntBits'(1);
            state <= S_OUT;
          end
        end
        S_MRD: begin
          top   <= rdata;
          state <= S_MUL;
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_SCMP;
          end else if (lo == top_idx) begin
            div_num <= top.succ;
            div_den <= top.trial;
            state   <= S_DINIT;
          end else begin
            state <= S_FRD;
          end
        end
        S_SCMP: begin
          if (rdata.last >= idx) begin
            hi <= mid;
          end else begin
            lo <= mid + IdxBits'(1);
          end
          state <= S_SRCH;
        end
        S_FRD: begin
          div_num <= rdata.succ;
          div_den <= rdata.trial;
          state   <= S_DINIT;
        end
        S_DINIT: begin
          if (div_num == div_den) begin
            quot <= FitBits'(1);
            rem  <= '0;
          end else begin
            quot <= '0;
            rem  <= {1'b0, div_num};
          end
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, div_den}) begin
            rem  <= rem_sh - {1'b0, div_den};
            quot <= {quot[FitBits-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[FitBits-2:0], 1'b0};
          end
          if (div_cnt == DivCntBits'(FracBits - 1)) begin
            state <= S_OUT;
          end
          div_cnt <= div_cnt + DivCntBits'(1);
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.status       <= res_status;
            out_data.fitted_value <= (res_status == ST_OK && div_cnt == DivCntBits'(FracBits)
                                      && in_data_was_read) ? quot : res_fit;
            out_data.points_held  <= point_count;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_was_read <= 1'b0;
    end else if (state == S_IDLE && in_valid) begin
      in_data_was_read <= (cmd_t'(in_data.command) == CMD_READ) &&
                          (CntBits'(in_data.point_index) < point_count);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/irp_checker.sv =====
// Port-level checker for the isotonic regression block, bound to its top level.
// Depends on irp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module irp_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_stall,
  input irp_pkg::out_beat_t  out_data
);
  import irp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output beat valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output beat changed.");

  a_fit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.fitted_value == '0)
    else $error("Fitted value not zero on a failed command.");

  a_fit_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fitted_value <= FitBits'(1 << FracBits))
    else $error("Fitted value above one.");

  a_held_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.points_held <= CntBits'(MaxPoints))
    else $error("Points held above capacity.");

endmodule

bind isotonic_regression_pava irp_checker u_irp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
